@@ rtl/mmp_pkg.sv @@
package mmp_pkg;

  localparam int VAL_W        = 31;
  localparam int SIZE_W       = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int PROD_W       = 2 * VAL_W;
  localparam int RED_W        = 2 * VAL_W + 1;
  localparam int MAX_SIZE_DEF = 8;

  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(8);
  localparam logic [VAL_W-1:0]  EXP_RST  = VAL_W'(1);
  localparam logic [VAL_W-1:0]  MOD_RST  = VAL_W'(1000000007);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE = 2'd0,
    CFG_EXP  = 2'd1,
    CFG_MOD  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    WD_RED  = 2'd0,
    WD_SCR  = 2'd1,
    WD_ONE  = 2'd2,
    WD_ZERO = 2'd3
  } wsel_e;

  typedef struct packed {
    logic  we_base;
    logic  we_power;
    logic  we_scratch;
    wsel_e wsel;
    logic  sel_a_power;
    logic  mul_load;
    logic  red_start;
    logic  red_src_entry;
    logic  sum_load;
    logic  sum_clear;
    logic  out_load;
  } cmd_t;

endpackage

@@ rtl/mmp_if.sv @@
interface mmp_entry_if;
  logic                       valid;
  logic                       ready;
  logic [mmp_pkg::VAL_W-1:0]  entry_value;
  logic                       last_entry;
  modport source (output valid, entry_value, last_entry, input ready);
  modport sink (input valid, entry_value, last_entry, output ready);
endinterface

interface mmp_result_if;
  logic                       valid;
  logic                       ready;
  logic [mmp_pkg::VAL_W-1:0]  result_value;
  logic                       last_result;
  modport source (output valid, result_value, last_result, input ready);
  modport sink (input valid, result_value, last_result, output ready);
endinterface

interface mmp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mmp_pkg::CFG_IDX_W-1:0] index;
  logic [mmp_pkg::VAL_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/mmp_ram.sv @@
module mmp_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr0_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr1_i,
  output logic [WIDTH-1:0]                             rdata0_o,
  output logic [WIDTH-1:0]                             rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

@@ rtl/mmp_modred.sv @@
// Bit-serial reduction of a wide value modulo m, one bit per cycle, MSB first.
module mmp_modred (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mmp_pkg::RED_W-1:0]     value_i,
  input  logic [mmp_pkg::VAL_W-1:0]     modulus_i,
  output logic                          done_o,
  output logic [mmp_pkg::VAL_W-1:0]     result_o
);

  localparam int STEPS = mmp_pkg::RED_W;
  localparam int CNT_W = $clog2(STEPS);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [mmp_pkg::RED_W-1:0]     sh_q, sh_d;
  logic [mmp_pkg::VAL_W-1:0]     rem_q, rem_d;
  logic [mmp_pkg::VAL_W:0]       dbl;

  always_comb begin
    dbl    = {rem_q, sh_q[mmp_pkg::RED_W-1]};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = value_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (dbl >= {1'b0, modulus_i}) begin
        dbl = dbl - {1'b0, modulus_i};
      end
      rem_d = dbl[mmp_pkg::VAL_W-1:0];
      sh_d  = {sh_q[mmp_pkg::RED_W-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign done_o   = done_q;
  assign result_o = rem_q;

endmodule

@@ rtl/mmp_datapath.sv @@
module mmp_datapath #(
  parameter int MAX_SIZE = mmp_pkg::MAX_SIZE_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mmp_pkg::cmd_t                         cmd_i,
  input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1)-1:0] raddr0_i,
  input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1)-1:0] raddr1_i,
  input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1)-1:0] waddr_i,
  input  logic [mmp_pkg::VAL_W-1:0]             entry_i,
  input  logic [mmp_pkg::VAL_W-1:0]             modulus_i,
  output logic                                  red_done_o,
  output logic [mmp_pkg::VAL_W-1:0]             result_o
);

  localparam int DEPTH = MAX_SIZE * MAX_SIZE;

  logic [mmp_pkg::VAL_W-1:0]  wdata;
  logic [mmp_pkg::VAL_W-1:0]  base_rd0, base_rd1, power_rd0, scr_rd0;
  logic [mmp_pkg::VAL_W-1:0]  op_a;
  logic [mmp_pkg::PROD_W-1:0] prod_q;
  logic [mmp_pkg::VAL_W-1:0]  sum_q;
  logic [mmp_pkg::VAL_W-1:0]  res_q;
  logic [mmp_pkg::RED_W-1:0]  red_value;
  logic [mmp_pkg::VAL_W-1:0]  red_result;

  always_comb begin
    case (cmd_i.wsel)
      mmp_pkg::WD_RED:  wdata = red_result;
      mmp_pkg::WD_SCR:  wdata = scr_rd0;
      mmp_pkg::WD_ONE:  wdata = (modulus_i == mmp_pkg::VAL_W'(1)) ? '0 : mmp_pkg::VAL_W'(1);
      default:          wdata = '0;
    endcase
  end

  mmp_ram #(.WIDTH(mmp_pkg::VAL_W), .DEPTH(DEPTH)) u_base (
    .clk_i, .we_i(cmd_i.we_base), .waddr_i, .wdata_i(wdata),
    .raddr0_i, .raddr1_i, .rdata0_o(base_rd0), .rdata1_o(base_rd1)
  );

  mmp_ram #(.WIDTH(mmp_pkg::VAL_W), .DEPTH(DEPTH)) u_power (
    .clk_i, .we_i(cmd_i.we_power), .waddr_i, .wdata_i(wdata),
    .raddr0_i, .raddr1_i('0), .rdata0_o(power_rd0), .rdata1_o()
  );

  mmp_ram #(.WIDTH(mmp_pkg::VAL_W), .DEPTH(DEPTH)) u_scratch (
    .clk_i, .we_i(cmd_i.we_scratch), .waddr_i, .wdata_i(wdata),
    .raddr0_i, .raddr1_i('0), .rdata0_o(scr_rd0), .rdata1_o()
  );

  assign op_a = cmd_i.sel_a_power ? power_rd0 : base_rd0;
  assign red_value = cmd_i.red_src_entry ? mmp_pkg::RED_W'(entry_i)
                   : mmp_pkg::RED_W'(prod_q) + mmp_pkg::RED_W'(sum_q);

  mmp_modred u_red (
    .clk_i, .rst_ni, .start_i(cmd_i.red_start), .value_i(red_value),
    .modulus_i, .done_o(red_done_o), .result_o(red_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (cmd_i.sum_clear) begin
      sum_q <= '0;
    end else if (cmd_i.sum_load) begin
      sum_q <= red_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      prod_q <= mmp_pkg::PROD_W'(op_a) * mmp_pkg::PROD_W'(base_rd1);
    end
    if (cmd_i.out_load) begin
      res_q <= power_rd0;
    end
  end

  assign result_o = res_q;

endmodule

@@ rtl/mmp_ctrl.sv @@
module mmp_ctrl #(
  parameter int MAX_SIZE = mmp_pkg::MAX_SIZE_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_last_i,
  output logic                                  in_ready_o,
  output logic                                  out_valid_o,
  output logic                                  out_last_o,
  input  logic                                  out_ready_i,
  input  logic [$clog2(MAX_SIZE + 1)-1:0]       size_i,
  input  logic [mmp_pkg::VAL_W-1:0]             exponent_i,
  input  logic                                  red_done_i,
  output mmp_pkg::cmd_t                         cmd_o,
  output logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1)-1:0] raddr0_o,
  output logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1)-1:0] raddr1_o,
  output logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1)-1:0] waddr_o
);

  localparam int NW = $clog2(MAX_SIZE + 1);
  localparam int CW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1;

  typedef enum logic [12:0] {
    S_IDLE   = 13'h0001,
    S_LOAD   = 13'h0002,
    S_INIT   = 13'h0004,
    S_EXP    = 13'h0008,
    S_MREAD  = 13'h0010,
    S_MMUL   = 13'h0020,
    S_MRED   = 13'h0040,
    S_MWAIT  = 13'h0080,
    S_CREAD  = 13'h0100,
    S_CWRITE = 13'h0200,
    S_OREAD  = 13'h0400,
    S_OLOAD  = 13'h0800,
    S_OSEND  = 13'h1000
  } state_e;

  state_e                    state_q, state_d;
  logic [AW-1:0]             load_q, load_d;
  logic                      last_q, last_d;
  logic                      pb_q, pb_d;
  logic [mmp_pkg::VAL_W-1:0] rem_q, rem_d;
  logic [CW-1:0]             r_q, r_d, c_q, c_d, k_q, k_d;
  logic [AW:0]               cells;
  logic [AW-1:0]             load_at;
  logic                      r_last, c_last, k_last, rc_last;
  logic [CW-1:0]             r_nx, c_nx;

  function automatic logic [AW-1:0] rc_addr(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                            input logic [NW-1:0] nn);
    logic [AW+CW:0] p;
    p = (AW + CW + 1)'(a) * (AW + CW + 1)'(nn) + (AW + CW + 1)'(b);
    return p[AW-1:0];
  endfunction

  assign cells   = (AW + 1)'(size_i) * (AW + 1)'(size_i);
  assign load_at = ((AW + 1)'(load_q) >= cells - (AW + 1)'(1))
                 ? AW'(cells - (AW + 1)'(1)) : load_q;
  assign r_last  = (NW'(r_q) == size_i - NW'(1));
  assign c_last  = (NW'(c_q) == size_i - NW'(1));
  assign k_last  = (NW'(k_q) == size_i - NW'(1));
  assign rc_last = r_last && c_last;
  assign c_nx    = c_last ? '0 : c_q + CW'(1);
  assign r_nx    = c_last ? (r_last ? '0 : r_q + CW'(1)) : r_q;

  always_comb begin
    state_d     = state_q;
    load_d      = load_q;
    last_d      = last_q;
    pb_d        = pb_q;
    rem_d       = rem_q;
    r_d         = r_q;
    c_d         = c_q;
    k_d         = k_q;
    cmd_o       = '0;
    cmd_o.wsel  = mmp_pkg::WD_RED;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    raddr0_o    = rc_addr(r_q, c_q, size_i);
    raddr1_o    = rc_addr(k_q, c_q, size_i);
    waddr_o     = rc_addr(r_q, c_q, size_i);
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.red_start     = 1'b1;
          cmd_o.red_src_entry = 1'b1;
          last_d              = in_last_i;
          state_d             = S_LOAD;
        end
      end
      S_LOAD: begin
        waddr_o = load_at;
        if (red_done_i) begin
          cmd_o.we_base = 1'b1;
          if (last_q) begin
            load_d  = '0;
            r_d     = '0;
            c_d     = '0;
            rem_d   = exponent_i;
            state_d = S_INIT;
          end else begin
            load_d  = ((AW + 1)'(load_at) < cells - (AW + 1)'(1)) ? load_at + AW'(1) : load_at;
            state_d = S_IDLE;
          end
        end
      end
      S_INIT: begin
        cmd_o.we_power = 1'b1;
        cmd_o.wsel     = (r_q == c_q) ? mmp_pkg::WD_ONE : mmp_pkg::WD_ZERO;
        r_d            = r_nx;
        c_d            = c_nx;
        if (rc_last) begin
          state_d = S_EXP;
        end
      end
      S_EXP: begin
        r_d = '0;
        c_d = '0;
        k_d = '0;
        if (rem_q == '0) begin
          state_d = S_OREAD;
        end else begin
          pb_d    = rem_q[0];
          state_d = S_MREAD;
        end
      end
      S_MREAD: begin
        raddr0_o = rc_addr(r_q, k_q, size_i);
        state_d  = S_MMUL;
      end
      S_MMUL: begin
        cmd_o.sel_a_power = pb_q;
        cmd_o.mul_load    = 1'b1;
        state_d           = S_MRED;
      end
      S_MRED: begin
        cmd_o.red_start = 1'b1;
        state_d         = S_MWAIT;
      end
      S_MWAIT: begin
        if (red_done_i) begin
          if (k_last) begin
            cmd_o.we_scratch = 1'b1;
            cmd_o.sum_clear  = 1'b1;
            k_d              = '0;
            r_d              = r_nx;
            c_d              = c_nx;
            state_d          = rc_last ? S_CREAD : S_MREAD;
          end else begin
            cmd_o.sum_load = 1'b1;
            k_d            = k_q + CW'(1);
            state_d        = S_MREAD;
          end
        end
      end
      S_CREAD: begin
        state_d = S_CWRITE;
      end
      S_CWRITE: begin
        cmd_o.wsel     = mmp_pkg::WD_SCR;
        cmd_o.we_power = pb_q;
        cmd_o.we_base  = !pb_q;
        r_d            = r_nx;
        c_d            = c_nx;
        if (rc_last) begin
          if (pb_q) begin
            pb_d    = 1'b0;
            k_d     = '0;
            state_d = S_MREAD;
          end else begin
            rem_d   = rem_q >> 1;
            state_d = S_EXP;
          end
        end else begin
          state_d = S_CREAD;
        end
      end
      S_OREAD: begin
        state_d = S_OLOAD;
      end
      S_OLOAD: begin
        cmd_o.out_load = 1'b1;
        state_d        = S_OSEND;
      end
      S_OSEND: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          r_d     = r_nx;
          c_d     = c_nx;
          state_d = rc_last ? S_IDLE : S_OREAD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_last_o = rc_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      load_q  <= '0;
      last_q  <= 1'b0;
      pb_q    <= 1'b0;
      rem_q   <= '0;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      load_q  <= load_d;
      last_q  <= last_d;
      pb_q    <= pb_d;
      rem_q   <= rem_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
    end
  end

endmodule

@@ rtl/modular_matrix_power.sv @@
// Modular matrix power: loads an N x N matrix entry by entry in row-major
// order on entry_i, the final entry marked by last_entry. The marked request
// starts the job: the matrix is raised to the configured exponent modulo the
// configured modulus by square-and-multiply from the identity, and the N*N
// result entries leave on result_o in row-major order, last_result marking
// the final one. cfg_i writes matrix_size (0), exponent (1) and modulus (2)
// and is always ready; write it only while no job is under way.
// Each entry request is reduced modulo the modulus by a bit-serial unit
// that handles one bit of a 63-bit word per cycle, and no further entry
// is taken until that reduction is done. Every multiply-accumulate reads,
// multiplies and takes 63 reduction steps. A job runs bits(exponent) +
// ones(exponent) matrix products after identity setup. Each result is
// read and registered before it is offered, and the next waits until it
// is taken. A stalled receiver simply holds the block in its output phase
// with the result steady; no new entry is taken until the last result is
// gone. Reset returns the controller to idle and the registers to size 8,
// exponent 1 and modulus 1000000007. Matrix memories are not cleared.
module modular_matrix_power #(
  parameter int MAX_SIZE = mmp_pkg::MAX_SIZE_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mmp_entry_if.sink     entry_i,
  mmp_result_if.source  result_o,
  mmp_cfg_if.sink       cfg_i
);

  localparam int NW = $clog2(MAX_SIZE + 1);
  localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1;

  // Configuration registers.
  logic [mmp_pkg::SIZE_W-1:0] size_q;
  logic [mmp_pkg::VAL_W-1:0]  exp_q;
  logic [mmp_pkg::VAL_W-1:0]  mod_q;

  // Size and modulus as actually applied: a size of zero acts as one, a size
  // above the build limit is clamped, and a zero modulus acts as one.
  logic [NW-1:0]              size_eff;
  logic [mmp_pkg::VAL_W-1:0]  mod_eff;

  mmp_pkg::cmd_t cmd;
  logic [AW-1:0] raddr0, raddr1, waddr;
  logic          red_done;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= mmp_pkg::SIZE_RST;
      exp_q  <= mmp_pkg::EXP_RST;
      mod_q  <= mmp_pkg::MOD_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        mmp_pkg::CFG_SIZE: size_q <= cfg_i.data[mmp_pkg::SIZE_W-1:0];
        mmp_pkg::CFG_EXP:  exp_q  <= cfg_i.data;
        mmp_pkg::CFG_MOD:  mod_q  <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  assign size_eff = (size_q == '0) ? NW'(1)
                  : (int'(size_q) > MAX_SIZE) ? NW'(MAX_SIZE) : NW'(size_q);
  assign mod_eff  = (mod_q == '0) ? mmp_pkg::VAL_W'(1) : mod_q;

  // The controller sequences loading, the exponent loop and the output sweep.
  mmp_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (entry_i.valid),
    .in_last_i   (entry_i.last_entry),
    .in_ready_o  (entry_i.ready),
    .out_valid_o (result_o.valid),
    .out_last_o  (result_o.last_result),
    .out_ready_i (result_o.ready),
    .size_i      (size_eff),
    .exponent_i  (exp_q),
    .red_done_i  (red_done),
    .cmd_o       (cmd),
    .raddr0_o    (raddr0),
    .raddr1_o    (raddr1),
    .waddr_o     (waddr)
  );

  // The datapath holds the three matrix memories, the multiplier and the
  // serial modular reducer.
  mmp_datapath #(.MAX_SIZE(MAX_SIZE)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i      (cmd),
    .raddr0_i   (raddr0),
    .raddr1_i   (raddr1),
    .waddr_i    (waddr),
    .entry_i    (entry_i.entry_value),
    .modulus_i  (mod_eff),
    .red_done_o (red_done),
    .result_o   (result_o.result_value)
  );

`ifndef SYNTH
  // The block never offers a result while it is taking entries.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(result_o.valid && entry_i.ready))
    else $error("result offered while entries are accepted");

  // Once the final result is taken, the block is ready for a new matrix.
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.ready && result_o.last_result) |=> entry_i.ready)
    else $error("not ready after final result");

  // The reducer completion is a single-cycle pulse.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_done |=> !red_done)
    else $error("reducer done held for more than one cycle");

  // A reduction never starts while a multiply operand load is requested.
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.red_start && cmd.mul_load))
    else $error("reduction start collides with multiply load");
`endif

endmodule
